// ----- src/odo_pkg.sv -----
// Shared types, constants and helper functions of the wheel odometry block.
`timescale 1ns / 1ps
package odo_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_N           = 24;
	localparam int QDEPTH           = 2;

	// register map, selected by paddr[2]
	localparam logic REG_WHEEL_RADIUS = 1'b0;
	localparam logic REG_TRACK_WIDTH  = 1'b1;

	localparam logic [15:0] WR_RESET = 16'd3211;
	localparam logic [15:0] TW_RESET = 16'd8631;

	// pi/180 in Q30
	localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
	localparam logic [32:0] TWO_PI_U       = 33'd6746518852;
	localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
	localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;

	typedef struct packed {
		logic signed [32:0] dl;
		logic signed [32:0] dr;
	} odo_delta_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd843314856;
			5'd1:  v = 32'd497837829;
			5'd2:  v = 32'd263043836;
			5'd3:  v = 32'd133525158;
			5'd4:  v = 32'd67021686;
			5'd5:  v = 32'd33543515;
			5'd6:  v = 32'd16775850;
			5'd7:  v = 32'd8388437;
			5'd8:  v = 32'd4194282;
			5'd9:  v = 32'd2097149;
			5'd10: v = 32'd1048575;
			5'd11: v = 32'd524287;
			5'd12: v = 32'd262143;
			5'd13: v = 32'd131071;
			5'd14: v = 32'd65535;
			5'd15: v = 32'd32767;
			5'd16: v = 32'd16383;
			5'd17: v = 32'd8191;
			5'd18: v = 32'd4095;
			5'd19: v = 32'd2047;
			5'd20: v = 32'd1023;
			5'd21: v = 32'd511;
			5'd22: v = 32'd255;
			5'd23: v = 32'd127;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
		logic signed [31:0] r;
		if (v > 96'sd2147483647) begin
			r = 32'sh7fff_ffff;
		end else if (v < -96'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- src/odo_fifo.sv -----
// Short request queue between the sample front end and the odometry engine.
`timescale 1ns / 1ps
module odo_fifo import odo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  odo_delta_t din,
	output logic       full,
	input  logic       pop,
	output odo_delta_t dout,
	output logic       empty
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNTW = $clog2(QDEPTH + 1);

	odo_delta_t ent_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full  = (count_q == CNTW'(QDEPTH));
	assign empty = (count_q == '0);
	assign dout  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

// ----- src/odo_front.sv -----
// Sample front end: takes encoder counts, forms count changes, queues them.
`timescale 1ns / 1ps
module odo_front import odo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	input  logic               q_full,
	output logic               q_push,
	output odo_delta_t         q_din
);

	logic signed [31:0] last_left_q, last_right_q;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// exact 33-bit change, current minus previous
	always_comb begin
		q_din.dl = 33'(left_count) - 33'(last_left_q);
		q_din.dr = 33'(right_count) - 33'(last_right_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left_q  <= '0;
			last_right_q <= '0;
		end else if (q_push) begin
			last_left_q  <= left_count;
			last_right_q <= right_count;
		end
	end

endmodule

// ----- src/odo_back.sv -----
// Odometry engine: arcs, heading divide, CORDIC and position update.
`timescale 1ns / 1ps
module odo_back import odo_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               q_pop,
	input  odo_delta_t         q_head,
	input  logic [15:0]        wheel_radius,
	input  logic [15:0]        track_width,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading,
	output logic signed [31:0] travelled
);

	localparam int S     = 46 - FRAC_BITS;
	localparam int RW    = 74 - S;
	localparam int AW    = RW + 2;
	localparam int CW    = (AW > 48) ? AW : 48;
	localparam int ZSH   = 30 - FRAC_BITS;
	localparam int ZMW   = 62 - FRAC_BITS;
	localparam int QB    = 29 - FRAC_BITS;
	localparam int NSTEP = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_ARC_M    = 4'd1;
	localparam logic [3:0] ST_ARC_LO   = 4'd2;
	localparam logic [3:0] ST_ARC_HI   = 4'd3;
	localparam logic [3:0] ST_ARC_SUM  = 4'd4;
	localparam logic [3:0] ST_DIV_INIT = 4'd5;
	localparam logic [3:0] ST_DIV      = 4'd6;
	localparam logic [3:0] ST_THETA    = 4'd7;
	localparam logic [3:0] ST_ZLOAD    = 4'd8;
	localparam logic [3:0] ST_MOD      = 4'd9;
	localparam logic [3:0] ST_FOLD     = 4'd10;
	localparam logic [3:0] ST_CORDIC   = 4'd11;
	localparam logic [3:0] ST_PX       = 4'd12;
	localparam logic [3:0] ST_PY       = 4'd13;
	localparam logic [3:0] ST_PYACC    = 4'd14;
	localparam logic [3:0] ST_DONE     = 4'd15;

	logic [3:0] st_q;
	logic [4:0] cnt_q;
	logic       side_q;
	logic       out_valid_q;
	logic signed [31:0] x_acc_q, y_acc_q, th_q, dist_q;

	odo_delta_t         delta_q;
	logic [64:0]        prod_q;
	logic [48:0]        m_q;
	logic [73:0]        acc_q;
	logic signed [AW-1:0] arc_l_q, arc_r_q, d_q;
	logic [15:0]        rem_q;
	logic [63:0]        num_q;
	logic               dneg_q;
	logic [ZMW-1:0]     zmag_q, dv_q;
	logic               zneg_q, flip_q;
	logic signed [32:0] cx_q, cy_q;
	logic signed [34:0] cz_q;
	logic signed [31:0] pos_x_q, pos_y_q, heading_q, travelled_q;

	logic [32:0] mul_a;
	logic [31:0] mul_b;
	logic        out_load;
	logic [15:0] tw_eff;

	logic signed [32:0] ds;
	logic [32:0]        dmag;
	logic [73:0]        arc_full;
	logic [RW-1:0]      arc_mag;
	logic signed [AW-1:0] arc_val;
	logic signed [AW-1:0] sum, diff, sum_adj, d_val;
	logic [AW-1:0]      dfm;
	logic [CW-1:0]      dfe;
	logic [46:0]        md;
	logic [63:0]        num_init;
	logic [15:0]        rem_n;
	logic [63:0]        num_n;
	logic [16:0]        r17;
	logic signed [65:0] q66, dth;
	logic [31:0]        tmag;
	logic signed [34:0] z0, z1, z2;
	logic               fl;
	logic signed [32:0] xs, ys;
	logic signed [34:0] at;
	logic [AW-1:0]      dd;
	logic [32:0]        dcmag;
	logic [31:0]        xmag, ymag;
	logic               c_neg, s_neg, pneg;
	logic [65:0]        pr_round;
	logic [35:0]        pr_mag;
	logic signed [36:0] pv;

	assign q_pop    = (st_q == ST_IDLE) && !q_empty;
	assign out_load = (st_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign tw_eff   = (track_width == 16'd0) ? 16'd1 : track_width;

	// arc of one wheel
	always_comb begin
		ds       = side_q ? delta_q.dr : delta_q.dl;
		dmag     = ds[32] ? 33'(-ds) : 33'(ds);
		arc_full = acc_q + {prod_q[49:0], 24'b0};
		arc_mag  = RW'(arc_full >> S);
		arc_val  = ds[32] ? -$signed({2'b0, arc_mag}) : $signed({2'b0, arc_mag});
	end

	// mean arc, heading numerator
	always_comb begin
		sum      = arc_l_q + arc_r_q;
		diff     = arc_r_q - arc_l_q;
		sum_adj  = sum + $signed({{(AW-1){1'b0}}, sum[AW-1]});
		d_val    = sum_adj >>> 1;
		dfm      = diff[AW-1] ? AW'(-diff) : AW'(diff);
		dfe      = CW'(dfm);
		md       = (dfe > CW'(64'd1 << 46)) ? 47'(64'd1 << 46) : 47'(dfe);
		num_init = {1'b0, md, 16'b0} + 64'(tw_eff[15:1]);
	end

	// two restoring divide steps per cycle
	always_comb begin
		rem_n = rem_q;
		num_n = num_q;
		r17   = '0;
		for (int j = 0; j < 2; j++) begin
			r17   = {rem_n, num_n[63]};
			num_n = {num_n[62:0], 1'b0};
			if (r17 >= {1'b0, tw_eff}) begin
				r17      = r17 - {1'b0, tw_eff};
				num_n[0] = 1'b1;
			end
			rem_n = r17[15:0];
		end
	end

	always_comb begin
		q66  = $signed({2'b0, num_q});
		dth  = dneg_q ? -q66 : q66;
		tmag = th_q[31] ? 32'(-th_q) : 32'(th_q);
	end

	// bring the reduced angle into [-pi/2, pi/2]
	always_comb begin
		z0 = zneg_q ? -$signed({2'b0, zmag_q[32:0]}) : $signed({2'b0, zmag_q[32:0]});
		z1 = z0;
		if (z1 > PI_Q30) begin
			z1 = z1 - TWO_PI_Q30;
		end
		if (z1 < -PI_Q30) begin
			z1 = z1 + TWO_PI_Q30;
		end
		fl = 1'b0;
		z2 = z1;
		if (z1 > HALF_PI_Q30) begin
			z2 = z1 - PI_Q30;
			fl = 1'b1;
		end else if (z1 < -HALF_PI_Q30) begin
			z2 = z1 + PI_Q30;
			fl = 1'b1;
		end
	end

	always_comb begin
		xs = cx_q >>> cnt_q;
		ys = cy_q >>> cnt_q;
		at = $signed({3'b0, atan_q30(cnt_q)});
	end

	// position step operands and rounding
	always_comb begin
		dd       = d_q[AW-1] ? AW'(-d_q) : AW'(d_q);
		dcmag    = (dd > AW'(64'd1 << 32)) ? 33'(64'd1 << 32) : 33'(dd);
		xmag     = cx_q[32] ? 32'(-cx_q) : 32'(cx_q);
		ymag     = cy_q[32] ? 32'(-cy_q) : 32'(cy_q);
		c_neg    = flip_q ^ cx_q[32];
		s_neg    = flip_q ^ cy_q[32];
		pneg     = d_q[AW-1] ^ ((st_q == ST_PY) ? c_neg : s_neg);
		pr_round = 66'(prod_q) + (66'd1 << 29);
		pr_mag   = 36'(pr_round >> 30);
		pv       = pneg ? -$signed({1'b0, pr_mag}) : $signed({1'b0, pr_mag});
	end

	// shared multiplier operand select
	always_comb begin
		case (st_q)
			ST_ARC_M: begin
				mul_a = dmag;
				mul_b = {16'b0, wheel_radius};
			end
			ST_ARC_LO: begin
				mul_a = {9'b0, prod_q[23:0]};
				mul_b = {7'b0, DEG_TO_RAD_Q30};
			end
			ST_ARC_HI: begin
				mul_a = {8'b0, m_q[48:24]};
				mul_b = {7'b0, DEG_TO_RAD_Q30};
			end
			ST_PX: begin
				mul_a = dcmag;
				mul_b = xmag;
			end
			ST_PY: begin
				mul_a = dcmag;
				mul_b = ymag;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			side_q      <= 1'b0;
			out_valid_q <= 1'b0;
			x_acc_q     <= '0;
			y_acc_q     <= '0;
			th_q        <= '0;
			dist_q      <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						side_q <= 1'b0;
						st_q   <= ST_ARC_M;
					end
				end
				ST_ARC_M:   st_q <= ST_ARC_LO;
				ST_ARC_LO:  st_q <= ST_ARC_HI;
				ST_ARC_HI:  st_q <= ST_ARC_SUM;
				ST_ARC_SUM: begin
					side_q <= 1'b1;
					st_q   <= side_q ? ST_DIV_INIT : ST_ARC_M;
				end
				ST_DIV_INIT: begin
					dist_q <= sat32(96'(dist_q) + 96'(d_val));
					cnt_q  <= '0;
					st_q   <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						st_q <= ST_THETA;
					end
				end
				ST_THETA: begin
					th_q <= sat32(96'(th_q) + 96'(dth));
					st_q <= ST_ZLOAD;
				end
				ST_ZLOAD: begin
					cnt_q <= 5'(QB - 1);
					st_q  <= ST_MOD;
				end
				ST_MOD: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						st_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					cnt_q <= '0;
					st_q  <= ST_CORDIC;
				end
				ST_CORDIC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(NSTEP - 1)) begin
						st_q <= ST_PX;
					end
				end
				ST_PX: st_q <= ST_PY;
				ST_PY: begin
					x_acc_q <= sat32(96'(x_acc_q) + 96'(pv));
					st_q    <= ST_PYACC;
				end
				ST_PYACC: begin
					y_acc_q <= sat32(96'(y_acc_q) + 96'(pv));
					st_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (q_pop) begin
			delta_q <= q_head;
		end
		case (st_q)
			ST_ARC_LO: m_q <= prod_q[48:0];
			ST_ARC_HI: acc_q <= {25'b0, prod_q[48:0]} + (74'd1 << (S - 1));
			ST_ARC_SUM: begin
				if (side_q) begin
					arc_r_q <= arc_val;
				end else begin
					arc_l_q <= arc_val;
				end
			end
			ST_DIV_INIT: begin
				d_q    <= d_val;
				dneg_q <= diff[AW-1];
				num_q  <= num_init;
				rem_q  <= '0;
			end
			ST_DIV: begin
				num_q <= num_n;
				rem_q <= rem_n;
			end
			ST_ZLOAD: begin
				zmag_q <= ZMW'(tmag) << ZSH;
				zneg_q <= th_q[31];
				dv_q   <= ZMW'(TWO_PI_U) << (QB - 1);
			end
			ST_MOD: begin
				if (zmag_q >= dv_q) begin
					zmag_q <= zmag_q - dv_q;
				end
				dv_q <= dv_q >> 1;
			end
			ST_FOLD: begin
				cz_q   <= z2;
				flip_q <= fl;
				cx_q   <= GAIN_Q30;
				cy_q   <= '0;
			end
			ST_CORDIC: begin
				if (!cz_q[34]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			pos_x_q     <= x_acc_q;
			pos_y_q     <= y_acc_q;
			heading_q   <= th_q;
			travelled_q <= dist_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign heading   = heading_q;
	assign travelled = travelled_q;

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (rem_q < tw_eff))
		else $error("divider remainder not below divisor");

	a_mod_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MOD) |-> ({1'b0, zmag_q} < {dv_q, 1'b0}))
		else $error("angle reduction out of range");

	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CORDIC && cnt_q == '0) |->
		(cz_q <= HALF_PI_Q30 && cz_q >= -HALF_PI_Q30))
		else $error("folded angle outside half pi");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && out_valid_q && out_stall) |=> (st_q == ST_DONE))
		else $error("result dropped while output slot busy");

endmodule

// ----- src/differential_drive_odometry.sv -----
// Top level of the differential-drive wheel odometry block.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall) carries one request: the left and
//   right wheel encoder counts in degrees. Output channel (out_valid /
//   out_stall) returns one result per request: pos_x, pos_y, heading and
//   travelled, all signed Q16.16 and saturating.
//   The front end takes a request, forms the count changes and parks them
//   in a two-entry queue, so until the queue is full it keeps accepting
//   while the engine works and while a finished result waits on the output
//   register. The engine is a sequencer around one shared 33x32 multiplier:
//   dispatch, arc math, setup, a radix-4 heading divide, heading update,
//   angle reduction, fold, CORDIC and position update. It takes a new
//   request only after the previous result has entered the output register.
//   Reset clears the previous counts and all accumulators, loads the
//   default wheel radius and track width and drops any queued requests.
//   When the receiver stalls, the result holds; the engine waits in its last
//   state and the queue then fills and raises in_stall.
//   Registers: wheel_radius at 0x0, track_width at 0x4; write only while idle.
module differential_drive_odometry import odo_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading,
	output logic signed [31:0] travelled
);

	logic [15:0] wheel_radius_q, track_width_q;
	logic        cfg_wr;
	logic        q_full, q_empty, q_push, q_pop;
	odo_delta_t  q_din, q_head;

	// register port: zero wait states, word select on paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_radius_q <= WR_RESET;
			track_width_q  <= TW_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WHEEL_RADIUS: wheel_radius_q <= pwdata[15:0];
				REG_TRACK_WIDTH:  track_width_q  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WHEEL_RADIUS: prdata = {16'b0, wheel_radius_q};
			REG_TRACK_WIDTH:  prdata = {16'b0, track_width_q};
			default:          prdata = '0;
		endcase
	end

	// front end: count changes into the queue
	odo_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.left_count  (left_count),
		.right_count (right_count),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_din       (q_din)
	);

	odo_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty)
	);

	// engine: one request at a time, result held in its output register
	odo_back #(
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_head       (q_head),
		.wheel_radius (wheel_radius_q),
		.track_width  (track_width_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.heading      (heading),
		.travelled    (travelled)
	);

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the differential-drive wheel odometry block.
`timescale 1ns / 1ps

// Tracks the odometry state on the side and holds the outputs still owed by the block.
class odo_tracker;
	typedef struct {
		int x;
		int y;
		int hd;
		int trav;
	} pose_t;

	pose_t owed[$];
	bit [15:0] radius;
	bit [15:0] track;
	longint prev_l;
	longint prev_r;
	int x_sum;
	int y_sum;
	int th_sum;
	int dist_sum;
	int errs;
	int checked;

	function new();
		radius = odo_pkg::WR_RESET;
		track = odo_pkg::TW_RESET;
		prev_l = 0;
		prev_r = 0;
		x_sum = 0;
		y_sum = 0;
		th_sum = 0;
		dist_sum = 0;
		errs = 0;
		checked = 0;
	endfunction

	function int sat(longint v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return int'(v);
	endfunction

	// wheel arc in Q16.16, rounded half away from zero
	function longint arc_len(longint delta);
		logic [127:0] m;
		longint mag;
		mag = delta < 0 ? -delta : delta;
		m = 128'(mag) * 128'(radius) * 128'(odo_pkg::DEG_TO_RAD_Q30) + (128'd1 << 29);
		m = m >> 30;
		return delta < 0 ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function longint mul_round(longint a, longint b);
		logic [127:0] p;
		longint ma;
		longint mb;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		p = (128'(ma) * 128'(mb) + (128'd1 << 29)) >> 30;
		return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	task automatic rotate(input int theta, output longint c, output longint s);
		longint z;
		longint x;
		longint y;
		longint nx;
		longint atan_tab[24];
		bit flip;
		atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
			16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
			65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
		z = longint'(theta) * 64'sd16384;
		z = z % 64'sd6746518852;
		if (z > 64'sd3373259426) z -= 64'sd6746518852;
		if (z < -64'sd3373259426) z += 64'sd6746518852;
		flip = 0;
		if (z > 64'sd1686629713) begin
			z -= 64'sd3373259426;
			flip = 1;
		end else if (z < -64'sd1686629713) begin
			z += 64'sd3373259426;
			flip = 1;
		end
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_tab[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_tab[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// advance the pose by one accepted encoder request
	task automatic note_request(input int lc, input int rc);
		longint dl;
		longint dr;
		longint d;
		longint diff;
		longint md;
		longint dth;
		longint dc;
		longint c;
		longint s;
		logic [127:0] q;
		longint tw;
		pose_t p;
		dl = arc_len(longint'(lc) - prev_l);
		dr = arc_len(longint'(rc) - prev_r);
		d = (dl + dr) / 2;
		diff = dr - dl;
		if (diff > (64'sd1 << 46)) diff = 64'sd1 << 46;
		if (diff < -(64'sd1 << 46)) diff = -(64'sd1 << 46);
		tw = (track == 0) ? 1 : longint'(track);
		md = diff < 0 ? -diff : diff;
		q = ((128'(md) << 16) + 128'(tw / 2)) / 128'(tw);
		dth = diff < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
		prev_l = lc;
		prev_r = rc;
		dist_sum = sat(longint'(dist_sum) + d);
		th_sum = sat(longint'(th_sum) + dth);
		rotate(th_sum, c, s);
		dc = d;
		if (dc > (64'sd1 << 32)) dc = 64'sd1 << 32;
		if (dc < -(64'sd1 << 32)) dc = -(64'sd1 << 32);
		x_sum = sat(longint'(x_sum) + mul_round(dc, c));
		y_sum = sat(longint'(y_sum) + mul_round(dc, s));
		p.x = x_sum;
		p.y = y_sum;
		p.hd = th_sum;
		p.trav = dist_sum;
		owed.push_back(p);
	endtask

	function void check_result(int x, int y, int hd, int trav);
		pose_t p;
		if (owed.size() == 0) begin
			$display("%0t: unexpected result x=%0d y=%0d heading=%0d travelled=%0d",
				$time, x, y, hd, trav);
			errs++;
			return;
		end
		p = owed.pop_front();
		checked++;
		if (x != p.x) begin
			$display("%0t: pos_x expected %0d actual %0d", $time, p.x, x);
			errs++;
		end
		if (y != p.y) begin
			$display("%0t: pos_y expected %0d actual %0d", $time, p.y, y);
			errs++;
		end
		if (hd != p.hd) begin
			$display("%0t: heading expected %0d actual %0d", $time, p.hd, hd);
			errs++;
		end
		if (trav != p.trav) begin
			$display("%0t: travelled expected %0d actual %0d", $time, p.trav, trav);
			errs++;
		end
	endfunction
endclass

module tb_top;
	import odo_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	// drain with margin after the last owed result
	localparam int DRAIN_CYCLES = 100;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] left_count;
	logic signed [31:0] right_count;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] heading;
	logic signed [31:0] travelled;

	odo_tracker pose;
	int sent;
	int cycles;
	int phases;
	bit calm;	// when set, neither side idles
	int cur_l;
	int cur_r;
	int stall_left;

	differential_drive_odometry DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.left_count(left_count), .right_count(right_count),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading), .travelled(travelled)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// hard stop on a hung handshake
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// receiver: draw a stall length after every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				pose.check_result(pos_x, pos_y, heading, travelled);
				stall_left = calm ? 0 : $urandom_range(0, 9);
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0) stall_left--;
		end
	end

	// one APB write: setup cycle, then access cycle; pready is tied high
	task automatic reg_write(input logic sel, input logic [15:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {sel, 2'b00};
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (sel == REG_WHEEL_RADIUS) pose.radius = val;
		else pose.track = val;
	endtask

	// drain outstanding results, then set both registers
	task automatic reconfigure(input logic [15:0] rad, input logic [15:0] trk);
		in_valid <= 0;
		while (pose.owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		reg_write(REG_WHEEL_RADIUS, rad);
		reg_write(REG_TRACK_WIDTH, trk);
		phases++;
		calm = ($urandom_range(0, 3) == 0);
	endtask

	// present one request; keep valid high when no gap is drawn
	task automatic send(input int lc, input int rc);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		left_count <= lc;
		right_count <= rc;
		do @(posedge clk); while (in_stall);
		pose.note_request(lc, rc);
		sent++;
		cur_l = lc;
		cur_r = rc;
	endtask

	// mostly smooth motion around the last counts, with some jumps and noise
	task automatic random_burst(input int n);
		int pick;
		int span;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			span = ($urandom_range(0, 4) == 0) ? 100000 : 720;
			if (pick < 80) begin
				send(cur_l + $urandom_range(0, 2 * span) - span,
					cur_r + $urandom_range(0, 2 * span) - span);
			end else if (pick < 90) begin
				send($urandom, $urandom);
			end else if (pick < 95) begin
				send(cur_l, cur_r);
			end else begin
				send(cur_l + $urandom_range(0, 360), cur_l + $urandom_range(0, 360));
			end
		end
	endtask

	initial begin
		pose = new();
		cycles = 0;
		sent = 0;
		phases = 0;
		calm = 0;
		cur_l = 0;
		cur_r = 0;
		stall_left = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		in_valid = 0;
		left_count = 0;
		right_count = 0;
		out_stall = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset geometry, standstill, extremes, straight and spin
		send(0, 0);
		send(360, 360);
		send(0, 720);
		send(32'sh7fff_ffff, 32'sh7fff_ffff);
		send(32'sh8000_0000, 32'sh7fff_ffff);
		send(32'sh7fff_ffff, 32'sh8000_0000);
		send(-1, -1);
		send(32'sh5555_5555, 32'shaaaa_aaaa);
		send(32'shaaaa_aaaa, 32'sh5555_5555);
		// extreme geometry: largest radius, narrowest track
		reconfigure(16'hffff, 16'd1);
		send(cur_l + 1, cur_r - 1);
		send(cur_l - 90, cur_r + 90);
		send(32'sh8000_0000, 32'sh8000_0000);
		// zero track width behaves as one
		reconfigure(16'd1, 16'd0);
		send(cur_l + 1000, cur_r - 1000);
		send(cur_l + 3, cur_r + 3);
		// zero radius: only the stored counts move
		reconfigure(16'd0, 16'hffff);
		send(1234, -5678);
		send(32'sh7fff_ffff, 32'sh8000_0000);
		// small radius resumes from the counts latched above
		reconfigure(16'd1, 16'hffff);
		send(cur_l - 1, cur_r + 1);

		reconfigure(WR_RESET, TW_RESET);
		random_burst(400);
		reconfigure(16'hffff, 16'hffff);
		random_burst(200);
		reconfigure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
		random_burst(300);
		reconfigure(16'($urandom_range(100, 8000)), 16'($urandom_range(2000, 30000)));
		random_burst(300);
		reconfigure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		random_burst(250);

		in_valid <= 0;
		while (pose.owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("tb_top: %0d encoder requests sent, %0d poses checked", sent, pose.checked);
		$display("tb_top: %0d geometry settings incl. zero radius and zero track", phases + 1);
		if (pose.errs == 0 && pose.owed.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
